@@ hdl/lpcls_pkg.sv @@
package lpcls_pkg;

   localparam int NUM_STAGES = 10;
   localparam int IDX_W      = $clog2(NUM_STAGES);
   localparam int EXC_W      = 8;
   localparam int GAIN_W     = 9;
   localparam int COEF_W     = 10;
   localparam int LAT_W      = 15;
   localparam int PCM_W      = 16;
   localparam int PROD_W     = COEF_W + LAT_W;
   localparam int PROD_SHIFT = 9;
   localparam int NUM_STEPS  = 22;
   localparam int STEP_W     = $clog2(NUM_STEPS);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   typedef enum logic {
      A_GAIN,
      A_COEF
   } mul_a_type;

   typedef enum logic [1:0] {
      B_EXC,
      B_BACK,
      B_FWD
   } mul_b_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [1:0] {
      BP_HOLD,
      BP_SHIFT,
      BP_TOP
   } bp_op_type;

   typedef enum logic {
      SEQ_NEXT,
      SEQ_END
   } seq_type;

   typedef struct packed {
      mul_a_type         mul_a;
      mul_b_type         mul_b;
      logic [IDX_W-1:0]  coef_idx;
      acc_op_type        acc_op;
      bp_op_type         bp_op;
      logic [IDX_W-1:0]  dst_idx;
      logic [IDX_W-1:0]  src_idx;
      seq_type           seq;
   } ucode_type;

   // The forward and backward passes are interleaved so that the single
   // multiplier is busy on almost every step. The product of a step is used
   // by the step after it.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{A_COEF, B_BACK, IDX_W'(0), ACC_HOLD, BP_HOLD, IDX_W'(0), IDX_W'(0), SEQ_NEXT};
      unique case (step)
         5'd0:  w = '{A_GAIN, B_EXC,  IDX_W'(0), ACC_HOLD, BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd1:  w = '{A_COEF, B_BACK, IDX_W'(9), ACC_LOAD, BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd2:  w = '{A_COEF, B_BACK, IDX_W'(8), ACC_SUB,  BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd3:  w = '{A_COEF, B_BACK, IDX_W'(7), ACC_SUB,  BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd4:  w = '{A_COEF, B_FWD,  IDX_W'(8), ACC_SUB,  BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd5:  w = '{A_COEF, B_BACK, IDX_W'(6), ACC_HOLD, BP_SHIFT, IDX_W'(9), IDX_W'(8),
                     SEQ_NEXT};
         5'd6:  w = '{A_COEF, B_FWD,  IDX_W'(7), ACC_SUB,  BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd7:  w = '{A_COEF, B_BACK, IDX_W'(5), ACC_HOLD, BP_SHIFT, IDX_W'(8), IDX_W'(7),
                     SEQ_NEXT};
         5'd8:  w = '{A_COEF, B_FWD,  IDX_W'(6), ACC_SUB,  BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd9:  w = '{A_COEF, B_BACK, IDX_W'(4), ACC_HOLD, BP_SHIFT, IDX_W'(7), IDX_W'(6),
                     SEQ_NEXT};
         5'd10: w = '{A_COEF, B_FWD,  IDX_W'(5), ACC_SUB,  BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd11: w = '{A_COEF, B_BACK, IDX_W'(3), ACC_HOLD, BP_SHIFT, IDX_W'(6), IDX_W'(5),
                     SEQ_NEXT};
         5'd12: w = '{A_COEF, B_FWD,  IDX_W'(4), ACC_SUB,  BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd13: w = '{A_COEF, B_BACK, IDX_W'(2), ACC_HOLD, BP_SHIFT, IDX_W'(5), IDX_W'(4),
                     SEQ_NEXT};
         5'd14: w = '{A_COEF, B_FWD,  IDX_W'(3), ACC_SUB,  BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd15: w = '{A_COEF, B_BACK, IDX_W'(1), ACC_HOLD, BP_SHIFT, IDX_W'(4), IDX_W'(3),
                     SEQ_NEXT};
         5'd16: w = '{A_COEF, B_FWD,  IDX_W'(2), ACC_SUB,  BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd17: w = '{A_COEF, B_BACK, IDX_W'(0), ACC_HOLD, BP_SHIFT, IDX_W'(3), IDX_W'(2),
                     SEQ_NEXT};
         5'd18: w = '{A_COEF, B_FWD,  IDX_W'(1), ACC_SUB,  BP_HOLD,  IDX_W'(0), IDX_W'(0),
                     SEQ_NEXT};
         5'd19: w = '{A_COEF, B_FWD,  IDX_W'(0), ACC_HOLD, BP_SHIFT, IDX_W'(2), IDX_W'(1),
                     SEQ_NEXT};
         5'd20: w = '{A_COEF, B_FWD,  IDX_W'(0), ACC_HOLD, BP_SHIFT, IDX_W'(1), IDX_W'(0),
                     SEQ_NEXT};
         5'd21: w = '{A_COEF, B_FWD,  IDX_W'(0), ACC_HOLD, BP_TOP,   IDX_W'(0), IDX_W'(0),
                     SEQ_END};
         default: w = '{A_COEF, B_BACK, IDX_W'(0), ACC_HOLD, BP_HOLD, IDX_W'(0), IDX_W'(0),
                       SEQ_END};
      endcase
      return w;
   endfunction

endpackage

@@ hdl/lpc_lattice_synth_filter_top.sv @@
// Ten-stage all-pole lattice synthesis filter for LPC speech.
//
// The req_ channel carries one excitation sample, an energy gain and ten
// reflection coefficients per transfer. The energy is applied to the next
// transfer, not to the one that carries it. The rsp_ channel returns one
// result per request: the raw lattice output wrapped to 15 bits and a 16-bit
// clipped, range-extended PCM sample.
//
// A short control program of 22 steps drives one shared 10 x 15-bit
// multiplier and a ten-entry backward-path store; each step issues at most
// one product. A new request is taken only after the program for the last one
// has ended, as req_ready is high only while the sequencer is idle.
//
// Reset clears the held energy and the backward path, so the first output
// after reset starts from a zero top input. If the receiver stalls with a
// result still waiting, the sequencer holds on its last step until the
// output register is free, so no result is lost.
module lpc_lattice_synth_filter_top import lpcls_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [EXC_W-1:0]  req_excitation,
   input  logic [GAIN_W-1:0]        req_energy,
   input  logic signed [COEF_W-1:0] req_refl_1,
   input  logic signed [COEF_W-1:0] req_refl_2,
   input  logic signed [COEF_W-1:0] req_refl_3,
   input  logic signed [COEF_W-1:0] req_refl_4,
   input  logic signed [COEF_W-1:0] req_refl_5,
   input  logic signed [COEF_W-1:0] req_refl_6,
   input  logic signed [COEF_W-1:0] req_refl_7,
   input  logic signed [COEF_W-1:0] req_refl_8,
   input  logic signed [COEF_W-1:0] req_refl_9,
   input  logic signed [COEF_W-1:0] req_refl_10,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [PCM_W-1:0]  rsp_pcm_out,
   output logic signed [LAT_W-1:0]  rsp_lattice_out
);

   state_type                 state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [EXC_W-1:0]   exc_ff;
   logic [GAIN_W-1:0]         gain_next_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic signed [COEF_W-1:0]  coef_ff [NUM_STAGES];
   logic [LAT_W-1:0]          acc_ff, acc_in;
   logic [LAT_W-1:0]          prod_ff, prod_in;
   logic [LAT_W-1:0]          back_mem_ff [NUM_STAGES];
   logic [NUM_STAGES-1:0]     back_vld_ff;
   logic [LAT_W-1:0]          rd_back_ff, rd_src_ff;
   logic                      rd_back_vld_ff, rd_src_vld_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PCM_W-1:0]          pcm_ff;
   logic [LAT_W-1:0]          lat_ff;

   ucode_type                 ucode, ucode_pre;
   logic                      accept, advance, finish, rd_en, back_we;
   logic signed [COEF_W-1:0]  op_a;
   logic signed [LAT_W-1:0]   op_b;
   logic signed [PROD_W-1:0]  product;
   logic [LAT_W-1:0]          rd_back, rd_src, wr_data;
   logic signed [LAT_W-1:0]   acc_s;
   logic [11:0]               clip;
   logic [PCM_W-1:0]          pcm_in;

   assign ucode     = ucode_rom(step_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign advance   = (state_ff == ST_RUN) &&
                      !(ucode.seq == SEQ_END && rsp_valid_ff && !rsp_ready);
   assign finish    = advance && (ucode.seq == SEQ_END);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end else if (advance) begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ucode_pre = ucode_rom(step_in);
   assign rd_en     = accept || advance;

   assign rd_back = rd_back_vld_ff ? rd_back_ff : '0;
   assign rd_src  = rd_src_vld_ff  ? rd_src_ff  : '0;

   assign op_a = (ucode.mul_a == A_GAIN) ? $signed({1'b0, gain_ff})
                                         : coef_ff[ucode.coef_idx];

   always_comb begin
      case (ucode.mul_b)
         B_EXC:   op_b = $signed({exc_ff[EXC_W-1], exc_ff, 6'b000000});
         B_BACK:  op_b = $signed(rd_back);
         B_FWD:   op_b = $signed(acc_ff);
         default: op_b = '0;
      endcase
   end

   // Arithmetic shift right rounds toward minus infinity; only the low
   // 15 bits of any value ever reach a later product or the output.
   assign product = op_a * op_b;
   assign prod_in = product[PROD_SHIFT +: LAT_W];

   always_comb begin
      case (ucode.acc_op)
         ACC_LOAD: acc_in = prod_ff;
         ACC_SUB:  acc_in = acc_ff - prod_ff;
         default:  acc_in = acc_ff;
      endcase
   end

   assign back_we = advance && (ucode.bp_op != BP_HOLD);
   assign wr_data = (ucode.bp_op == BP_TOP) ? acc_ff : rd_src + prod_ff;

   assign acc_s = $signed(acc_ff);
   always_comb begin
      if (acc_s > 15'sd2047) begin
         clip = 12'h7FF;
      end else if (acc_s < -15'sd2048) begin
         clip = 12'h800;
      end else begin
         clip = acc_ff[11:0];
      end
   end
   assign pcm_in = {clip[11:4], clip[10:4], clip[10]};

   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         gain_ff        <= '0;
         back_vld_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         rd_back_vld_ff <= 1'b0;
         rd_src_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && ucode.mul_a == A_GAIN) begin
            gain_ff <= gain_next_ff;
         end
         if (back_we) begin
            back_vld_ff[ucode.dst_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_back_vld_ff <= back_vld_ff[ucode_pre.coef_idx];
            rd_src_vld_ff  <= back_vld_ff[ucode_pre.src_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (back_we) begin
         back_mem_ff[ucode.dst_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_back_ff <= back_mem_ff[ucode_pre.coef_idx];
         rd_src_ff  <= back_mem_ff[ucode_pre.src_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         exc_ff       <= req_excitation;
         gain_next_ff <= req_energy;
         coef_ff[0]   <= req_refl_1;
         coef_ff[1]   <= req_refl_2;
         coef_ff[2]   <= req_refl_3;
         coef_ff[3]   <= req_refl_4;
         coef_ff[4]   <= req_refl_5;
         coef_ff[5]   <= req_refl_6;
         coef_ff[6]   <= req_refl_7;
         coef_ff[7]   <= req_refl_8;
         coef_ff[8]   <= req_refl_9;
         coef_ff[9]   <= req_refl_10;
      end
      if (advance) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
      if (finish) begin
         pcm_ff <= pcm_in;
         lat_ff <= acc_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pcm_out     = $signed(pcm_ff);
   assign rsp_lattice_out = $signed(lat_ff);

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RUN && step_ff == LAST_STEP))
      else $error("result raised outside the last program step");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN && step_ff == '0))
      else $error("request transfer did not start the program");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= LAST_STEP && !req_ready))
      else $error("program step out of range or request taken while running");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && ucode.seq == SEQ_END && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == ST_RUN && $stable(step_ff) && $stable(acc_ff)))
      else $error("sequencer left the last step while the output was full");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(back_vld_ff))
      else $error("backward path written while idle");
`endif

endmodule

@@ bench/tb_lpc_lattice_synth_filter_top.sv @@
module tb_lpc_lattice_synth_filter_top import lpcls_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 40;

   typedef struct packed {
      logic [EXC_W-1:0]                   excitation;
      logic [GAIN_W-1:0]                  energy;
      logic [NUM_STAGES-1:0][COEF_W-1:0]  refl;
   } synth_frame_type;

   typedef struct packed {
      logic [PCM_W-1:0] pcm;
      logic [LAT_W-1:0] lattice;
   } speech_sample_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [EXC_W-1:0]  req_excitation = '0;
   logic [GAIN_W-1:0]        req_energy = '0;
   logic signed [COEF_W-1:0] req_refl_1 = '0;
   logic signed [COEF_W-1:0] req_refl_2 = '0;
   logic signed [COEF_W-1:0] req_refl_3 = '0;
   logic signed [COEF_W-1:0] req_refl_4 = '0;
   logic signed [COEF_W-1:0] req_refl_5 = '0;
   logic signed [COEF_W-1:0] req_refl_6 = '0;
   logic signed [COEF_W-1:0] req_refl_7 = '0;
   logic signed [COEF_W-1:0] req_refl_8 = '0;
   logic signed [COEF_W-1:0] req_refl_9 = '0;
   logic signed [COEF_W-1:0] req_refl_10 = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [PCM_W-1:0]  rsp_pcm_out;
   logic signed [LAT_W-1:0]  rsp_lattice_out;

   synth_frame_type   pending_frames[$];
   speech_sample_type expected_samples[$];
   synth_frame_type   driven_frame = '0;
   int                sender_idle_pct = 26;
   int                receiver_idle_pct = 82;
   int                failures = 0;
   int                cycle_count = 0;

   logic [GAIN_W-1:0] held_gain = '0;
   int                back_path[NUM_STAGES] = '{default: 0};

   lpc_lattice_synth_filter_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_excitation  (req_excitation),
      .req_energy      (req_energy),
      .req_refl_1      (req_refl_1),
      .req_refl_2      (req_refl_2),
      .req_refl_3      (req_refl_3),
      .req_refl_4      (req_refl_4),
      .req_refl_5      (req_refl_5),
      .req_refl_6      (req_refl_6),
      .req_refl_7      (req_refl_7),
      .req_refl_8      (req_refl_8),
      .req_refl_9      (req_refl_9),
      .req_refl_10     (req_refl_10),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pcm_out     (rsp_pcm_out),
      .rsp_lattice_out (rsp_lattice_out)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int sign_wrap(int v, int bits);
      int sh;
      sh = 32 - bits;
      return (v <<< sh) >>> sh;
   endfunction

   // Both operands wrap to the multiplier widths; the shift rounds towards minus infinity.
   function automatic int scaled_product(int a, int b);
      return (sign_wrap(a, COEF_W) * sign_wrap(b, LAT_W)) >>> PROD_SHIFT;
   endfunction

   function automatic speech_sample_type synthesise(synth_frame_type f);
      int                fwd[NUM_STAGES+1];
      int                i;
      int                s;
      int                c;
      logic [15:0]       u;
      speech_sample_type r;
      fwd[NUM_STAGES] = scaled_product(int'(held_gain), int'($signed(f.excitation)) * 64);
      for (i = NUM_STAGES - 1; i >= 0; i--) begin
         fwd[i] = fwd[i+1] - scaled_product(int'($signed(f.refl[i])), back_path[i]);
      end
      for (i = NUM_STAGES - 1; i >= 1; i--) begin
         back_path[i] = sign_wrap(back_path[i-1]
                                  + scaled_product(int'($signed(f.refl[i-1])), fwd[i-1]), 24);
      end
      back_path[0] = sign_wrap(fwd[0], 24);
      held_gain = f.energy;
      s = sign_wrap(fwd[0], LAT_W);
      c = (s > 2047) ? 2047 : ((s < -2048) ? -2048 : s);
      u = c[15:0] & 16'hFFF0;
      r.pcm = (u << 4) | ((u & 16'h07F0) >> 3) | ((u & 16'h0400) >> 10);
      r.lattice = s[LAT_W-1:0];
      return r;
   endfunction

   function automatic synth_frame_type random_frame();
      synth_frame_type f;
      int              mode;
      int              i;
      mode = $urandom_range(99);
      f.excitation = EXC_W'($urandom);
      f.energy = GAIN_W'($urandom);
      for (i = 0; i < NUM_STAGES; i++) begin
         if (mode < 25) begin
            f.refl[i] = COEF_W'($urandom_range(511) - 256);
         end else if (mode < 40) begin
            case ($urandom_range(3))
               0: f.refl[i] = COEF_W'(10'h200);
               1: f.refl[i] = COEF_W'(10'h1FF);
               2: f.refl[i] = '0;
               default: f.refl[i] = COEF_W'($urandom);
            endcase
         end else begin
            f.refl[i] = COEF_W'($urandom);
         end
      end
      if (mode >= 25 && mode < 40) begin
         f.excitation = $urandom_range(1) ? EXC_W'(8'h80) : EXC_W'(8'h7F);
         f.energy = $urandom_range(1) ? GAIN_W'(511) : GAIN_W'($urandom);
      end
      return f;
   endfunction

   task automatic queue_frame(int exc, int gain, int k);
      synth_frame_type f;
      int              i;
      f.excitation = EXC_W'(exc);
      f.energy = GAIN_W'(gain);
      for (i = 0; i < NUM_STAGES; i++) begin
         f.refl[i] = COEF_W'(k);
      end
      pending_frames.push_back(f);
   endtask

   task automatic drain();
      while (pending_frames.size() > 0 || req_valid || expected_samples.size() > 0) begin
         @(negedge clock);
      end
   endtask

   always @(posedge clock) begin : frame_driver
      synth_frame_type f;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_frames.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            f = pending_frames.pop_front();
            driven_frame <= f;
            req_valid <= 1'b1;
            req_excitation <= f.excitation;
            req_energy <= f.energy;
            req_refl_1 <= f.refl[0];
            req_refl_2 <= f.refl[1];
            req_refl_3 <= f.refl[2];
            req_refl_4 <= f.refl[3];
            req_refl_5 <= f.refl[4];
            req_refl_6 <= f.refl[5];
            req_refl_7 <= f.refl[6];
            req_refl_8 <= f.refl[7];
            req_refl_9 <= f.refl[8];
            req_refl_10 <= f.refl[9];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : sample_checker
      speech_sample_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         if (req_valid && req_ready) begin
            expected_samples.push_back(synthesise(driven_frame));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: result transfer with none expected: pcm_out %h lattice_out %h",
                        $time, rsp_pcm_out, rsp_lattice_out);
               failures++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_pcm_out !== want.pcm) begin
                  $display("%0t: pcm_out expected %h actual %h", $time, want.pcm, rsp_pcm_out);
                  failures++;
               end
               if (rsp_lattice_out !== want.lattice) begin
                  $display("%0t: lattice_out expected %h actual %h",
                           $time, want.lattice, rsp_lattice_out);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      synth_frame_type f;
      int              n;
      int              i;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The first transfer after reset sees a zero held energy.
      queue_frame(127, 511, 0);
      queue_frame(-128, 511, 0);
      queue_frame(127, 0, 0);
      queue_frame(0, 0, 511);
      for (n = 0; n < 4; n++) begin
         queue_frame(-128, 511, -512);
      end
      for (n = 0; n < 4; n++) begin
         queue_frame(127, 511, 511);
      end
      for (n = 0; n < 4; n++) begin
         f.excitation = EXC_W'(64);
         f.energy = GAIN_W'(256);
         for (i = 0; i < NUM_STAGES; i++) begin
            f.refl[i] = (i % 2 == n % 2) ? COEF_W'(511) : COEF_W'(-512);
         end
         pending_frames.push_back(f);
      end
      for (n = 0; n < 3; n++) begin
         queue_frame(0, 0, 0);
      end
      queue_frame(-1, 1, -1);
      queue_frame(1, 511, 1);
      for (n = 0; n < 420; n++) begin
         pending_frames.push_back(random_frame());
      end
      drain();

      sender_idle_pct = 82;
      receiver_idle_pct = 26;
      for (n = 0; n < 420; n++) begin
         pending_frames.push_back(random_frame());
      end
      drain();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      for (n = 0; n < 410; n++) begin
         pending_frames.push_back(random_frame());
      end
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
